[sv/mlfs_pkg.sv]
// Package for the multilevel feedback scheduler: op codes, sizes and the
// controller-to-datapath command and status structs. No dependencies.
package mlfs_pkg;
	localparam int NUM_LEVELS = 4;
	localparam int MAX_TASKS  = 64;

	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_UNBLOCK = 3'd1,
		OP_TICK    = 3'd2,
		OP_BLOCK   = 3'd3,
		OP_EXIT    = 3'd4
	} op_t;

	localparam logic [2:0] REG_LEVELS = 3'd0;
	localparam logic [2:0] REG_Q0     = 3'd1;
	localparam logic [2:0] REG_Q1     = 3'd2;
	localparam logic [2:0] REG_Q2     = 3'd3;
	localparam logic [2:0] REG_Q3     = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch op and task id, start table reads
		logic execute;   // perform the op with read data available
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic has_result;
	} status_t;
endpackage

[sv/mlfs_ctrl.sv]
// Controller for the multilevel feedback scheduler: sequences capture,
// execute and result delivery. Depends on mlfs_pkg.
module mlfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  mlfs_pkg::status_t status,
	input  logic              out_fire,
	output logic              busy,
	output logic              out_valid,
	output mlfs_pkg::cmd_t    cmd
);
	typedef enum logic {S_IDLE, S_EXEC} state_t;
	state_t state_q;
	logic out_valid_q;
	logic stall;

	always_comb begin
		// hold execute while a new result would overwrite one still waiting
		stall = status.has_result && out_valid_q && !out_fire;
		cmd.capture = in_fire;
		cmd.execute = (state_q == S_EXEC) && !stall;
		busy = (state_q != S_IDLE);
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_EXEC;
					if (out_fire) out_valid_q <= 1'b0;
				end
				S_EXEC: begin
					if (!stall) begin
						state_q <= S_IDLE;
						if (status.has_result) out_valid_q <= 1'b1;
						else if (out_fire) out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[sv/mlfs_dp.sv]
// Datapath for the multilevel feedback scheduler: level table, queue
// memory, queue pointers and the running task. Depends on mlfs_pkg.
module mlfs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlfs_pkg::cmd_t                cmd,
	input  logic [2:0]                    in_op,
	input  logic [5:0]                    in_task,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_idx,
	input  logic [8:0]                    cfg_data,
	output mlfs_pkg::status_t             status,
	output logic [5:0]                    run_task,
	output logic                          run_idle
);
	localparam int NUM_LEVELS = mlfs_pkg::NUM_LEVELS;
	localparam int MAX_TASKS  = mlfs_pkg::MAX_TASKS;
	localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	logic [2:0] levels_q;
	logic [8:0] quant_q [4];

	logic [1:0]    tlevel_mem [MAX_TASKS];
	logic [TW-1:0] head_q [NUM_LEVELS];
	logic [TW-1:0] tail_q [NUM_LEVELS];
	logic [CW-1:0] cnt_q  [NUM_LEVELS];

	logic [TW-1:0] run_q;
	logic          valid_q;
	logic [7:0]    ticks_q;

	logic [2:0]    op_s1;
	logic [TW-1:0] tid_s1;
	logic          tid_ok_s1;
	logic [1:0]    lvl_in_s1;   // level of captured task
	logic [1:0]    lvl_run_s1;  // level of running task
	logic [TW-1:0] head_task_s1 [NUM_LEVELS];
	logic [5:0]    res_task_q;
	logic          res_idle_q;

	// level of the dispatched task, read at execute and registered
	logic [1:0]    lvl_rd_s2;
	logic          lvl_byp_s2;
	logic [1:0]    lvl_wr_s2;
	logic          load_s2;

	// active level count, clamped
	logic [3:0] act;
	always_comb begin
		act = {1'b0, levels_q};
		if (act == 4'd0) act = 4'd1;
		if (act > 4'(NUM_LEVELS)) act = 4'(NUM_LEVELS);
	end
	logic [3:0] last_lvl;
	assign last_lvl = act - 4'd1;

	// read cycle: latch item, read tables
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1     <= in_op;
			tid_s1    <= TW'(in_task);
			tid_ok_s1 <= (32'(in_task) < MAX_TASKS);
			lvl_in_s1 <= tlevel_mem[TW'(in_task)];
			lvl_run_s1 <= tlevel_mem[run_q];
		end
	end

	// execute: enqueue decision and dispatch selection
	logic          do_enq;
	logic [TW-1:0] enq_task;
	logic [3:0]    enq_lvl;
	logic          do_lvl_wr;
	logic [TW-1:0] lvl_wr_task;
	logic [1:0]    lvl_wr_val;
	logic          do_disp;
	logic          found;
	logic [LW-1:0] sel;
	logic [TW-1:0] new_task;
	logic [1:0]    new_lvl;
	logic [8:0]    q;
	logic          has_res;
	logic [3:0]    raw_lvl;
	logic [NUM_LEVELS-1:0] push_v;
	logic [NUM_LEVELS-1:0] pop_v;

	always_comb begin
		do_enq = 1'b0; enq_task = tid_s1; raw_lvl = 4'd0;
		do_lvl_wr = 1'b0; lvl_wr_task = run_q; lvl_wr_val = 2'd0;
		do_disp = 1'b0; has_res = 1'b0;
		case (op_s1)
			mlfs_pkg::OP_LOAD: begin
				do_enq = tid_ok_s1; raw_lvl = 4'd0;
			end
			mlfs_pkg::OP_UNBLOCK: begin
				do_enq = tid_ok_s1; raw_lvl = {2'b0, lvl_in_s1};
			end
			mlfs_pkg::OP_TICK: begin
				has_res = 1'b1;
				if (!valid_q) do_disp = 1'b1;
				else if (ticks_q == 8'd0) begin
					do_disp = 1'b1; do_enq = 1'b1; enq_task = run_q;
					raw_lvl = {2'b0, lvl_run_s1} + 4'd1;
				end
			end
			mlfs_pkg::OP_BLOCK: begin
				has_res = 1'b1; do_disp = 1'b1;
				if (valid_q && lvl_run_s1 != 2'd0) begin
					do_lvl_wr = 1'b1; lvl_wr_val = lvl_run_s1 - 2'd1;
				end
			end
			mlfs_pkg::OP_EXIT: begin
				has_res = 1'b1; do_disp = 1'b1;
			end
			default: ;
		endcase
		enq_lvl = (raw_lvl > last_lvl) ? last_lvl : raw_lvl;
		if (do_enq) begin
			do_lvl_wr = 1'b1; lvl_wr_task = enq_task; lvl_wr_val = enq_lvl[1:0];
		end
		// first non-empty level in use; enqueued task visible only by count
		found = 1'b0; sel = '0;
		for (int l = NUM_LEVELS-1; l >= 0; l--) begin
			if (4'(l) < act && (cnt_q[l] != '0 ||
			    (do_enq && enq_lvl == 4'(l) && cnt_q[l] != CW'(MAX_TASKS)))) begin
				found = 1'b1; sel = LW'(l);
			end
		end
		// an empty level just filled by this enqueue dispatches the enqueued task
		if (found && cnt_q[sel] == '0) new_task = enq_task;
		else new_task = head_task_s1[sel];
	end

	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			push_v[l] = do_enq && enq_lvl == 4'(l) && cnt_q[l] != CW'(MAX_TASKS);
			pop_v[l]  = do_disp && found && sel == LW'(l);
		end
	end

	// slice of the dispatched task, from its level after this op's level write
	always_comb begin
		new_lvl = lvl_byp_s2 ? lvl_wr_s2 : lvl_rd_s2;
		q = quant_q[new_lvl];
		if (q == 9'd0) q = 9'd1;
		if (q > 9'd256) q = 9'd256;
	end

	assign status.has_result = has_res;

	// one queue memory per level: write at tail, read head at capture
	for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
		logic [TW-1:0] fifo_mem [MAX_TASKS];
		logic [TW-1:0] head_rd_s1;
		always_ff @(posedge clk) begin
			if (cmd.execute && push_v[g]) fifo_mem[tail_q[g]] <= enq_task;
			if (cmd.capture) head_rd_s1 <= fifo_mem[head_q[g]];
		end
		assign head_task_s1[g] = head_rd_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (do_lvl_wr) tlevel_mem[lvl_wr_task] <= lvl_wr_val;
			lvl_rd_s2  <= tlevel_mem[new_task];
			lvl_byp_s2 <= do_lvl_wr && lvl_wr_task == new_task;
			lvl_wr_s2  <= lvl_wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= 3'd4;
			for (int i = 0; i < 4; i++) quant_q[i] <= 9'd1;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l] <= '0; tail_q[l] <= '0; cnt_q[l] <= '0;
			end
			run_q <= '0; valid_q <= 1'b0; ticks_q <= '0;
			res_task_q <= '0; res_idle_q <= 1'b1;
			load_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					mlfs_pkg::REG_LEVELS: levels_q <= cfg_data[2:0];
					mlfs_pkg::REG_Q0: quant_q[0] <= cfg_data;
					mlfs_pkg::REG_Q1: quant_q[1] <= cfg_data;
					mlfs_pkg::REG_Q2: quant_q[2] <= cfg_data;
					mlfs_pkg::REG_Q3: quant_q[3] <= cfg_data;
					default: ;
				endcase
			end
			// reload the slice the cycle after a dispatch found a task
			load_s2 <= cmd.execute && do_disp && found;
			if (load_s2) ticks_q <= 8'(q - 9'd1);
			if (cmd.execute) begin
				for (int l = 0; l < NUM_LEVELS; l++) begin
					if (push_v[l])
						tail_q[l] <= (32'(tail_q[l]) + 1 >= MAX_TASKS) ? '0 : tail_q[l] + 1'b1;
					if (pop_v[l])
						head_q[l] <= (32'(head_q[l]) + 1 >= MAX_TASKS) ? '0 : head_q[l] + 1'b1;
					if (push_v[l] && !pop_v[l]) cnt_q[l] <= cnt_q[l] + 1'b1;
					else if (pop_v[l] && !push_v[l]) cnt_q[l] <= cnt_q[l] - 1'b1;
				end
				if (op_s1 == mlfs_pkg::OP_TICK && valid_q && ticks_q != 8'd0) begin
					ticks_q <= ticks_q - 8'd1;
					res_task_q <= 6'(run_q); res_idle_q <= 1'b0;
				end else if (do_disp) begin
					valid_q <= found;
					run_q <= found ? new_task : '0;
					if (!found) ticks_q <= 8'd0;
					res_task_q <= found ? 6'(new_task) : 6'd0;
					res_idle_q <= !found;
				end
			end
		end
	end

	assign run_task = res_task_q;
	assign run_idle = res_idle_q;
endmodule

[sv/multilevel_feedback_scheduler.sv]
// Top level of the multilevel feedback queue scheduler.
// Instantiates mlfs_ctrl and mlfs_dp; uses mlfs_pkg.
//
// Usage:
//  - s_axis carries one event item: tdata[2:0] op, tdata[8:3] task_id.
//    Ops: load, unblock, tick, block, exit.
//  - m_axis carries the dispatch decision for tick, block and exit:
//    tdata[5:0] run_task, tuser run_idle. Load and unblock give no item.
//  - cfg_we/cfg_idx/cfg_data write levels_in_use (0) and the four
//    quanta (1..4); write only while no item is in flight.
// Timing: an item is taken and the queue tables are read at capture,
//  then the op is executed in the EXEC state, which registers the
//  result; the slice of a dispatched task is then reloaded through the
//  load_s2 register. No new item is taken until the last one has
//  executed, as the queue memory is read at capture and written at execute.
// s_axis_tready is low while an item is in work; a waiting result does not
//  block input, but a stalled receiver holds the result and holds the
//  execute of the next item that has a result until the old one is taken.
// Reset empties all queues, marks the CPU idle and loads four levels
//  with a one-tick quantum each; task levels and queue memory start
//  undefined and need no clearing pass.
module multilevel_feedback_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [2:0] op, [8:3] task_id
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [5:0] run_task
	output logic        m_axis_tuser,   // [0] run_idle
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [8:0]  cfg_data
);
	mlfs_pkg::cmd_t    cmd;
	mlfs_pkg::status_t status;
	logic busy;
	logic in_fire, out_fire;
	logic [5:0] run_task;

	assign s_axis_tready = !busy;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	mlfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .status(status),
		.out_fire(out_fire), .busy(busy), .out_valid(m_axis_tvalid), .cmd(cmd)
	);

	mlfs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_op(s_axis_tdata[2:0]), .in_task(s_axis_tdata[8:3]),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.status(status), .run_task(run_task), .run_idle(m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, run_task};
endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for multilevel_feedback_scheduler: random and directed event items,
// dispatch decisions checked against an in-bench scheduler model. Needs mlfs_pkg.
module tb;
	localparam int LEVELS = 4;
	localparam int TASKS  = 64;

	// Scheduler model plus the store of dispatch decisions still awaited.
	class DispatchScoreboard;
		bit [2:0]  levels_reg;
		bit [8:0]  quantum_reg[LEVELS];
		bit [1:0]  task_lvl[TASKS];
		bit [5:0]  ready_q[LEVELS][TASKS];
		int        q_head[LEVELS], q_tail[LEVELS], q_count[LEVELS];
		bit [5:0]  cur_task;
		bit        cur_valid;
		int        slice_left;
		bit [6:0]  expected_dispatches[$];
		int        mismatches;

		function new();
			levels_reg = 3'd4;
			foreach (quantum_reg[i]) quantum_reg[i] = 9'd1;
			foreach (task_lvl[i]) task_lvl[i] = '0;
			foreach (q_head[i]) begin
				q_head[i] = 0; q_tail[i] = 0; q_count[i] = 0;
			end
			cur_task = '0; cur_valid = 0; slice_left = 0; mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, bit [8:0] val);
			if (idx == mlfs_pkg::REG_LEVELS) levels_reg = val[2:0];
			else if (idx <= mlfs_pkg::REG_Q3) quantum_reg[idx - 1] = val;
		endfunction

		function int active_levels();
			if (levels_reg < 1) return 1;
			if (levels_reg > LEVELS) return LEVELS;
			return levels_reg;
		endfunction

		function int slice_of(int lvl);
			int q;
			q = quantum_reg[lvl > 3 ? 3 : lvl];
			if (q < 1) q = 1;
			if (q > 256) q = 256;
			return q;
		endfunction

		// Queue a task; clamp its level to the last one in use, drop on a full level.
		function void push_task(bit [5:0] t, int lvl);
			int last;
			last = active_levels() - 1;
			if (lvl > last) lvl = last;
			task_lvl[t] = 2'(lvl);
			if (q_count[lvl] >= TASKS) return;
			ready_q[lvl][q_tail[lvl]] = t;
			q_tail[lvl] = (q_tail[lvl] + 1) % TASKS;
			q_count[lvl]++;
		endfunction

		function void pick_next();
			cur_valid = 0; cur_task = '0; slice_left = 0;
			for (int l = 0; l < active_levels(); l++) begin
				if (q_count[l] != 0) begin
					cur_task = ready_q[l][q_head[l]];
					q_head[l] = (q_head[l] + 1) % TASKS;
					q_count[l]--;
					cur_valid = 1;
					slice_left = slice_of(task_lvl[cur_task]) - 1;
					return;
				end
			end
		endfunction

		function void note_event(logic [2:0] op, bit [5:0] tid);
			bit [6:0] exp_d;
			case (op)
				mlfs_pkg::OP_LOAD:    push_task(tid, 0);
				mlfs_pkg::OP_UNBLOCK: push_task(tid, task_lvl[tid]);
				mlfs_pkg::OP_TICK: begin
					if (!cur_valid) pick_next();
					else if (slice_left > 0) slice_left--;
					else begin
						push_task(cur_task, int'(task_lvl[cur_task]) + 1);
						pick_next();
					end
				end
				mlfs_pkg::OP_BLOCK: begin
					if (cur_valid && task_lvl[cur_task] > 0) task_lvl[cur_task]--;
					pick_next();
				end
				mlfs_pkg::OP_EXIT: pick_next();
				default: ;
			endcase
			if (op == mlfs_pkg::OP_TICK || op == mlfs_pkg::OP_BLOCK ||
			    op == mlfs_pkg::OP_EXIT) begin
				exp_d = {!cur_valid, cur_valid ? cur_task : 6'd0};
				expected_dispatches = {expected_dispatches, exp_d};
			end
		endfunction

		function void check_dispatch(bit [5:0] task_out, bit idle_out);
			bit [6:0] exp_d;
			if (expected_dispatches.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: run_task %0d run_idle %0d", task_out, idle_out);
				return;
			end
			exp_d = expected_dispatches.pop_front();
			if (exp_d[5:0] !== task_out || exp_d[6] !== idle_out) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected task %0d idle %0d, got task %0d idle %0d",
						exp_d[5:0], exp_d[6], task_out, idle_out);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we = 0;
	logic [2:0]  cfg_idx = '0;
	logic [8:0]  cfg_data = '0;

	DispatchScoreboard sb = new();
	bit known_task[TASKS];
	int known_count = 0;

	multilevel_feedback_scheduler dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#4ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Receiver: alternate ready stretches with stalls of random length.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			n = gap_len();
			m_axis_tready <= (n == 0);
			repeat (n > 0 ? n - 1 : $urandom_range(8)) @(negedge clk);
			m_axis_tready <= 1;
			repeat ($urandom_range(6)) @(negedge clk);
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_dispatch(m_axis_tdata[5:0], m_axis_tuser);

	// Present one event item and hold it until taken; returns at the next falling edge.
	task automatic send_event(logic [2:0] op, bit [5:0] tid);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {7'd0, tid, op};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_event(op, tid);
		if (op == mlfs_pkg::OP_LOAD && !known_task[tid]) begin
			known_task[tid] = 1;
			known_count++;
		end
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int n;
		n = gap_len();
		if (n > 0) begin
			s_axis_tvalid <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Hold input until every awaited decision has come, then let the pipe settle.
	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.expected_dispatches.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, bit [8:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_config(bit [2:0] lv, bit [8:0] q0, bit [8:0] q1, bit [8:0] q2,
		bit [8:0] q3);
		write_reg(mlfs_pkg::REG_LEVELS, 9'(lv));
		write_reg(mlfs_pkg::REG_Q0, q0);
		write_reg(mlfs_pkg::REG_Q1, q1);
		write_reg(mlfs_pkg::REG_Q2, q2);
		write_reg(mlfs_pkg::REG_Q3, q3);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function bit [5:0] pick_known();
		int k;
		k = $urandom_range(known_count - 1);
		foreach (known_task[i])
			if (known_task[i]) begin
				if (k == 0) return 6'(i);
				k--;
			end
		return 0;
	endfunction

	// Random events weighted toward ticks so tasks sink through the levels.
	task automatic random_phase(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 20 || (r < 35 && known_count == 0))
				send_event(mlfs_pkg::OP_LOAD, 6'($urandom_range(63)));
			else if (r < 35)
				send_event(mlfs_pkg::OP_UNBLOCK, pick_known());
			else if (r < 75)
				send_event(mlfs_pkg::OP_TICK, 6'($urandom_range(63)));
			else if (r < 85)
				send_event(mlfs_pkg::OP_BLOCK, 6'($urandom_range(63)));
			else if (r < 95)
				send_event(mlfs_pkg::OP_EXIT, 6'($urandom_range(63)));
			else
				send_event(3'($urandom_range(7, 5)), 6'($urandom_range(63)));
			sender_gap();
			if (i == count / 2 && $urandom_range(3) == 0) drain();
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: every op, idle cases, restart of a known task, undefined ops.
		send_event(mlfs_pkg::OP_TICK, 6'd0);
		send_event(mlfs_pkg::OP_BLOCK, 6'd0);
		send_event(mlfs_pkg::OP_EXIT, 6'd63);
		send_event(mlfs_pkg::OP_LOAD, 6'd0);
		send_event(mlfs_pkg::OP_LOAD, 6'd63);
		send_event(mlfs_pkg::OP_TICK, 6'd0);
		send_event(mlfs_pkg::OP_TICK, 6'd0);
		send_event(mlfs_pkg::OP_TICK, 6'd0);
		send_event(mlfs_pkg::OP_BLOCK, 6'd0);
		send_event(mlfs_pkg::OP_UNBLOCK, 6'd63);
		send_event(mlfs_pkg::OP_LOAD, 6'd63);
		send_event(3'd5, 6'd42);
		send_event(3'd6, 6'd21);
		send_event(3'd7, 6'd63);
		send_event(mlfs_pkg::OP_TICK, 6'd0);
		send_event(mlfs_pkg::OP_EXIT, 6'd0);
		send_event(mlfs_pkg::OP_EXIT, 6'd0);
		send_event(mlfs_pkg::OP_EXIT, 6'd0);
		send_event(mlfs_pkg::OP_UNBLOCK, 6'd0);
		send_event(mlfs_pkg::OP_TICK, 6'd0);
		drain();

		// Overflow level 0 so pushes get dropped, then empty it again.
		for (int i = 0; i < 70; i++) send_event(mlfs_pkg::OP_LOAD, 6'(i));
		for (int i = 0; i < 66; i++) send_event(mlfs_pkg::OP_EXIT, 6'd0);
		drain();

		random_phase(150);
		set_config(3'd1, 9'd1, 9'd256, 9'd256, 9'd256);
		random_phase(150);
		set_config(3'd4, 9'd256, 9'd3, 9'd5, 9'd511);
		random_phase(200);
		set_config(3'd0, 9'd0, 9'd0, 9'd0, 9'd0);
		random_phase(150);
		set_config(3'd7, 9'd2, 9'd4, 9'd8, 9'd16);
		random_phase(200);
		set_config(3'd2, 9'd1, 9'd1, 9'd1, 9'd1);
		random_phase(150);
		for (int p = 0; p < 4; p++) begin
			set_config(3'($urandom_range(7)), 9'($urandom_range(6)), 9'($urandom_range(9)),
				9'($urandom_range(12)), 9'($urandom_range(511)));
			random_phase(150);
		end

		if (sb.mismatches == 0 && sb.expected_dispatches.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
